### rtl/assert_macros.svh
// assertion helpers used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, muted while reset is low
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on the rising clock that also runs during reset
`define SFR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, codes and the crc-16 byte update shared by the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int HEADER_BYTES = 5;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // byte positions inside a frame
  localparam logic [8:0] POS_SYNC0 = 9'd0;
  localparam logic [8:0] POS_SYNC1 = 9'd1;
  localparam logic [8:0] POS_LEN   = 9'd2;
  localparam logic [8:0] POS_HCS   = 9'd3;
  localparam logic [8:0] POS_CRC   = 9'(HEADER_BYTES - 1);
  localparam logic [8:0] POS_BODY  = 9'(HEADER_BYTES);

  // end-of-frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CRC  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
  localparam logic [1:0] REG_MAX_BODY_LEN = 2'd2;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] max_body_len;
  } cfg_t;

  typedef struct packed {
    logic       has_data;
    logic [7:0] body_byte;
    logic       frame_done;
    logic [1:0] frame_status;
    logic [7:0] frame_length;
  } res_t;

  // crc-16 update by one byte, msb first, no reflection
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// APB register file holding the sync bytes and the body length limit.
// ----------------------------------------------------------------------------
module sfr_cfg_regs import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first   <= 8'd170;
      cfg_r.sync_second  <= 8'd85;
      cfg_r.max_body_len <= 8'd255;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SYNC_FIRST:   cfg_r.sync_first   <= pwdata[7:0];
        REG_SYNC_SECOND:  cfg_r.sync_second  <= pwdata[7:0];
        REG_MAX_BODY_LEN: cfg_r.max_body_len <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_SYNC_FIRST:   prdata = {24'd0, cfg_r.sync_first};
      REG_SYNC_SECOND:  prdata = {24'd0, cfg_r.sync_second};
      REG_MAX_BODY_LEN: prdata = {24'd0, cfg_r.max_body_len};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

### rtl/sfr_deframe.sv
// ----------------------------------------------------------------------------
// sfr_deframe
// Input register, header hunt and body crc, and the result register.
// ----------------------------------------------------------------------------
module sfr_deframe import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  exp_crc_r, exp_crc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r;
  res_t        res_r;

  logic        emit;
  logic        done;
  logic        has;
  logic [7:0]  hcs;
  logic [8:0]  taken;
  logic        s1_go;
  res_t        res_nxt;

  assign hcs   = cfg.sync_first + cfg.sync_second + len_r;
  assign taken = pos_r - POS_CRC;

  // frame state walk for the byte held in the input register
  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    exp_crc_nxt = exp_crc_r;
    crc_nxt     = crc_r;
    emit        = 1'b0;
    done        = 1'b0;
    has         = 1'b0;
    case (pos_r)
      POS_SYNC0: pos_nxt = (s1_byte_r == cfg.sync_first) ? POS_SYNC1 : POS_SYNC0;
      POS_SYNC1: pos_nxt = (s1_byte_r == cfg.sync_second) ? POS_LEN : POS_SYNC0;
      POS_LEN: begin
        len_nxt = s1_byte_r;
        pos_nxt = POS_HCS;
      end
      POS_HCS: pos_nxt = (s1_byte_r == hcs) ? POS_CRC : POS_SYNC0;
      POS_CRC: begin
        exp_crc_nxt = s1_byte_r;
        crc_nxt     = 16'd0;
        if (len_r == 8'd0) begin
          pos_nxt = POS_SYNC0;
          emit    = 1'b1;
          done    = 1'b1;
        end else begin
          pos_nxt = POS_BODY;
        end
      end
      default: begin
        crc_nxt = crc16_byte(crc_r, s1_byte_r);
        emit    = 1'b1;
        has     = 1'b1;
        if (taken >= {1'b0, len_r}) begin
          pos_nxt = POS_SYNC0;
          done    = 1'b1;
        end else begin
          pos_nxt = pos_r + 9'd1;
        end
      end
    endcase
  end

  // result fields, crc mismatch wins over the length limit
  always_comb begin
    res_nxt.has_data     = has;
    res_nxt.body_byte    = has ? s1_byte_r : 8'd0;
    res_nxt.frame_done   = done;
    res_nxt.frame_length = done ? len_r : 8'd0;
    if (!done) begin
      res_nxt.frame_status = ST_OK;
    end else if (crc_nxt[7:0] != exp_crc_nxt) begin
      res_nxt.frame_status = ST_BAD_CRC;
    end else if (len_r > cfg.max_body_len) begin
      res_nxt.frame_status = ST_TOO_LONG;
    end else begin
      res_nxt.frame_status = ST_OK;
    end
  end

  // the held byte moves on unless its result finds the output slot taken
  assign s1_go    = s1_valid_r & (~emit | ~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= POS_SYNC0;
      len_r     <= 8'd0;
      exp_crc_r <= 8'd0;
      crc_r     <= 16'd0;
    end else if (s1_go) begin
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      exp_crc_r <= exp_crc_nxt;
      crc_r     <= crc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

### rtl/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Byte-serial deframer: sync header hunt, body pass-through, crc-16 check.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | transfer when
//  ---------+-----------------------------------------+-----------------------
//  input    | in_valid in_ready in_rx_byte            | in_valid & in_ready
//  result   | out_valid out_ready out_has_data ...    | out_valid & out_ready
//  config   | psel penable pwrite paddr pwdata prdata | psel&penable&pwrite
//
//  one byte per cycle sustained unless the result side stalls; a byte is held
//  in the input register and its result, if any, then in the result register.
//  the crc update and header checks are combinational logic on the held byte.
//  a stalled result holds the input register once a second result is due;
//  header bytes never wait on the result side, except the crc byte of an
//  empty frame, which carries the frame end.
//  synchronous reset returns to the first-sync hunt with crc and lengths zero.
// ----------------------------------------------------------------------------
module serial_frame_receiver import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_has_data,
  output logic [7:0]  out_body_byte,
  output logic        out_frame_done,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_frame_length
);

  cfg_t cfg;
  res_t res;

  // configuration registers
  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // deframing datapath
  sfr_deframe u_deframe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res)
  );

  // result fields
  assign out_has_data     = res.has_data;
  assign out_body_byte    = res.body_byte;
  assign out_frame_done   = res.frame_done;
  assign out_frame_status = res.frame_status;
  assign out_frame_length = res.frame_length;

endmodule

### rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_checker import sfr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_has_data,
  input logic [7:0]  out_body_byte,
  input logic        out_frame_done,
  input logic [1:0]  out_frame_status,
  input logic [7:0]  out_frame_length
);

  logic [19:0] res_fields;
  logic        status_known;

  assign res_fields   = {out_has_data, out_body_byte, out_frame_done,
                         out_frame_status, out_frame_length};
  assign status_known = (out_frame_status == ST_OK) || (out_frame_status == ST_BAD_CRC) ||
                        (out_frame_status == ST_TOO_LONG);

  // no result survives a reset edge
  `SFR_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

  // a waiting input byte holds until taken
  `SFR_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_rx_byte), "input changed")

  // a stalled result holds its fields
  `SFR_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(res_fields), "stall")

  // every result carries a body byte or ends a frame, unused byte is zero
  `SFR_ASSERT(a_result_kind, out_valid |-> (out_has_data || out_frame_done) && (out_has_data || out_body_byte == 8'd0), "result kind")

  // status and length only on a frame end, and status is a known code
  `SFR_ASSERT(a_status_use, out_valid |-> (out_frame_done || (out_frame_status == ST_OK && out_frame_length == 8'd0)) && status_known, "status")

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

### sim/serial_frame_receiver_checker.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_checker
// Watches the config, input and result channels of the frame receiver. Each
// input transfer runs through a local model of the header hunt, body crc and
// end-of-frame status. Each result transfer is compared with the oldest
// predicted result.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checker import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_has_data,
  input  logic [7:0]  out_body_byte,
  input  logic        out_frame_done,
  input  logic [1:0]  out_frame_status,
  input  logic [7:0]  out_frame_length,
  output int          mismatches,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copy and frame tracking state
  cfg_t        regs;
  logic [8:0]  frame_pos;
  logic [7:0]  hdr_len;
  logic [7:0]  hdr_crc;
  logic [15:0] body_crc;
  res_t        expected_results[$];

  // crc-16 poly 0x1021, one data bit at a time, msb first
  function automatic logic [15:0] crc_shift_in(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    int          i;
    c = crc;
    for (i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // build one result; status only on the last item of a frame
  function automatic res_t make_result(input logic has, input logic [7:0] b, input logic done);
    res_t r;
    r = '0;
    r.has_data  = has;
    r.body_byte = has ? b : 8'h00;
    if (done) begin
      r.frame_done   = 1'b1;
      r.frame_length = hdr_len;
      if (body_crc[7:0] != hdr_crc) begin
        r.frame_status = ST_BAD_CRC;
      end else if (hdr_len > regs.max_body_len) begin
        r.frame_status = ST_TOO_LONG;
      end else begin
        r.frame_status = ST_OK;
      end
    end
    return r;
  endfunction

  // advance the deframer by one received byte
  task automatic predict_rx_byte(input logic [7:0] b);
    logic [8:0] taken;
    case (frame_pos)
      POS_SYNC0: begin
        frame_pos = (b == regs.sync_first) ? POS_SYNC1 : POS_SYNC0;
      end
      POS_SYNC1: begin
        frame_pos = (b == regs.sync_second) ? POS_LEN : POS_SYNC0;
      end
      POS_LEN: begin
        hdr_len   = b;
        frame_pos = POS_HCS;
      end
      POS_HCS: begin
        frame_pos = (b == 8'(regs.sync_first + regs.sync_second + hdr_len)) ? POS_CRC : POS_SYNC0;
      end
      POS_CRC: begin
        hdr_crc  = b;
        body_crc = 16'h0000;
        if (hdr_len == 8'd0) begin
          // empty body ends on the crc byte
          expected_results.push_back(make_result(1'b0, 8'h00, 1'b1));
          frame_pos = POS_SYNC0;
        end else begin
          frame_pos = POS_BODY;
        end
      end
      default: begin
        body_crc = crc_shift_in(body_crc, b);
        taken    = frame_pos - POS_BODY + 9'd1;
        if (taken >= {1'b0, hdr_len}) begin
          expected_results.push_back(make_result(1'b1, b, 1'b1));
          frame_pos = POS_SYNC0;
        end else begin
          expected_results.push_back(make_result(1'b1, b, 1'b0));
          frame_pos = frame_pos + 9'd1;
        end
      end
    endcase
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_result();
    res_t got;
    res_t want;
    got.has_data     = out_has_data;
    got.body_byte    = out_body_byte;
    got.frame_done   = out_frame_done;
    got.frame_status = out_frame_status;
    got.frame_length = out_frame_length;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result with nothing expected: has_data=%0d body_byte=%02h done=%0d status=%0d length=%0d",
                 $realtime, got.has_data, got.body_byte, got.frame_done,
                 got.frame_status, got.frame_length);
      end
    end else begin
      want = expected_results.pop_front();
      if (got.has_data !== want.has_data || got.body_byte !== want.body_byte ||
          got.frame_done !== want.frame_done || got.frame_status !== want.frame_status ||
          got.frame_length !== want.frame_length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch: expected has_data=%0d body_byte=%02h done=%0d status=%0d length=%0d",
                   $realtime, want.has_data, want.body_byte, want.frame_done,
                   want.frame_status, want.frame_length);
          $display("%0t:                  actual   has_data=%0d body_byte=%02h done=%0d status=%0d length=%0d",
                   $realtime, got.has_data, got.body_byte, got.frame_done,
                   got.frame_status, got.frame_length);
        end
      end
    end
  endtask

  // sample all channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      regs.sync_first   = 8'd170;
      regs.sync_second  = 8'd85;
      regs.max_body_len = 8'd255;
      frame_pos  = POS_SYNC0;
      hdr_len    = 8'd0;
      hdr_crc    = 8'd0;
      body_crc   = 16'h0000;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SYNC_FIRST:   regs.sync_first   = pwdata[7:0];
          REG_SYNC_SECOND:  regs.sync_second  = pwdata[7:0];
          REG_MAX_BODY_LEN: regs.max_body_len = pwdata[7:0];
          default: ;
        endcase
      end
      // a result can never come from the byte taken at this same edge
      if (out_valid && out_ready) begin
        check_result();
      end
      if (in_valid && in_ready) begin
        predict_rx_byte(in_rx_byte);
      end
    end
    results_pending <= expected_results.size();
  end

endmodule

### sim/serial_frame_receiver_test.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_test
// Drives byte streams into the frame receiver: a few directed frames and
// header faults, then random well-formed frames mixed with noise and broken
// headers under several sync and length-limit settings. Both channels idle
// at random. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module serial_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  typedef enum int {KIND_FRAME, KIND_NOISE, KIND_BROKEN} stim_kind_e;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_has_data;
  logic [7:0]  out_body_byte;
  logic        out_frame_done;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_frame_length;
  int          mismatches;
  int          results_pending;

  // settings last written, used to build frames
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;
  logic [7:0]  len_cap;

  // idle pattern state per side
  bit          in_calm;
  int          in_mode_left;
  bit          out_calm;
  int          out_mode_left;

  serial_frame_receiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_has_data     (out_has_data),
    .out_body_byte    (out_body_byte),
    .out_frame_done   (out_frame_done),
    .out_frame_status (out_frame_status),
    .out_frame_length (out_frame_length)
  );

  serial_frame_receiver_checker frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_has_data     (out_has_data),
    .out_body_byte    (out_body_byte),
    .out_frame_done   (out_frame_done),
    .out_frame_status (out_frame_status),
    .out_frame_length (out_frame_length),
    .mismatches       (mismatches),
    .results_pending  (results_pending)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // body crc for building frames
  function automatic logic [15:0] body_crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          k;
    c = crc ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // one input transfer after a random gap; starts and ends on a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (in_mode_left == 0) begin
      in_calm      = ($urandom_range(0, 2) == 0);
      in_mode_left = $urandom_range(10, 60);
    end
    in_mode_left--;
    gap = in_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // wait until every predicted result has come and the pipeline drained
  task automatic settle();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // apb write: setup then access
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_SYNC_FIRST:   sync_a  = value;
      REG_SYNC_SECOND:  sync_b  = value;
      REG_MAX_BODY_LEN: len_cap = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] cap);
    settle();
    cfg_write(REG_SYNC_FIRST, s0);
    cfg_write(REG_SYNC_SECOND, s1);
    cfg_write(REG_MAX_BODY_LEN, cap);
  endtask

  task automatic send_header(input logic [7:0] len, input logic [7:0] crc_b);
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(len);
    send_byte(8'(sync_a + sync_b + len));
    send_byte(crc_b);
  endtask

  // well-formed frame with random body, crc right or wrong
  task automatic send_frame(input int len, input bit good_crc);
    logic [7:0]  body[$];
    logic [15:0] crc;
    logic [7:0]  b;
    logic [7:0]  crc_b;
    int          i;
    crc = 16'h0000;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      body.push_back(b);
      crc = body_crc_next(crc, b);
    end
    crc_b = good_crc ? crc[7:0] : (crc[7:0] ^ 8'($urandom_range(1, 255)));
    send_header(8'(len), crc_b);
    foreach (body[j]) send_byte(body[j]);
  endtask

  // header cut short or with a bad sync or checksum byte
  task automatic send_broken(output int sent);
    logic [7:0] hdr[5];
    logic [7:0] len;
    int         last;
    int         i;
    len    = 8'($urandom_range(0, 6));
    hdr[0] = sync_a;
    hdr[1] = sync_b;
    hdr[2] = len;
    hdr[3] = 8'(sync_a + sync_b + len);
    hdr[4] = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: last = int'(POS_SYNC0);
      1: last = int'(POS_SYNC1);
      2: last = int'(POS_HCS);
      default: last = -1;
    endcase
    if (last >= 0) begin
      hdr[last] = hdr[last] ^ 8'($urandom_range(1, 255));
    end else begin
      // truncated header, the next bytes fall into it
      last = $urandom_range(0, 3);
    end
    for (i = 0; i <= last; i++) send_byte(hdr[i]);
    sent = last + 1;
  endtask

  // mostly well-formed frames, some noise and broken headers
  task automatic run_phase(input int budget);
    int         taken;
    int         len;
    int         pick;
    int         sent;
    int         i;
    stim_kind_e kind;
    taken = 0;
    while (taken < budget) begin
      pick = $urandom_range(0, 19);
      kind = (pick < 14) ? KIND_FRAME : (pick < 17) ? KIND_NOISE : KIND_BROKEN;
      case (kind)
        KIND_FRAME: begin
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            len = $urandom_range(0, 6);
          end else if (pick < 9) begin
            len = $urandom_range(7, 24);
          end else begin
            len = $urandom_range(25, 60);
          end
          send_frame(len, $urandom_range(0, 4) != 0);
          taken += len + HEADER_BYTES;
        end
        KIND_NOISE: begin
          for (i = $urandom_range(1, 4); i > 0; i--) begin
            send_byte(8'($urandom_range(0, 255)));
          end
        end
        default: begin
          send_broken(sent);
          taken += sent;
        end
      endcase
    end
  endtask

  // result side ready pattern
  initial begin
    int stall;
    out_ready     = 1'b0;
    out_calm      = 1'b0;
    out_mode_left = 0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (out_mode_left == 0) begin
        out_calm      = ($urandom_range(0, 2) == 0);
        out_mode_left = $urandom_range(10, 60);
      end
      out_mode_left--;
      stall = out_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 4'h0;
    pwdata       = 32'h0;
    in_valid     = 1'b0;
    in_rx_byte   = 8'h00;
    sync_a       = 8'd170;
    sync_b       = 8'd85;
    len_cap      = 8'd255;
    in_calm      = 1'b0;
    in_mode_left = 0;
    rst_n        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty body, good and bad crc
    send_header(8'd0, 8'h00);
    send_header(8'd0, 8'hff);
    // wrong second sync byte
    send_byte(sync_a);
    send_byte(sync_b ^ 8'hff);
    // wrong header checksum
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'h01);
    send_byte(8'(sync_a + sync_b + 8'h01) ^ 8'h80);
    // two-byte body with the extreme byte values
    send_header(8'd2, 8'(body_crc_next(body_crc_next(16'h0000, 8'h00), 8'hff)));
    send_byte(8'h00);
    send_byte(8'hff);
    run_phase(80);

    // every non-empty body too long
    apply_setting(8'h00, 8'hff, 8'h00);
    run_phase(80);

    // longest body once
    apply_setting(8'hff, 8'h00, 8'hff);
    send_frame(255, 1'b1);
    run_phase(60);

    apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(1, 20)));
    run_phase(90);

    // same value for both sync bytes
    sync_a = 8'($urandom_range(0, 255));
    apply_setting(sync_a, sync_a, 8'($urandom_range(0, 255)));
    run_phase(80);

    apply_setting(8'd170, 8'd85, 8'd8);
    run_phase(80);

    settle();
    if (mismatches == 0 && results_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
